[rtl/core/mmrs_pkg.sv]
// Shared constants, types and helpers for the streaming matrix multiplier.
`timescale 1ns / 1ps

package mmrs_pkg;

  localparam int MAX_DIM     = 16;
  localparam int ELEM_W      = 16;
  localparam int ACC_W       = 36;
  localparam int DIM_W       = $clog2(MAX_DIM);
  localparam int DIMV_W      = DIM_W + 1;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int ST_DEPTH    = MAX_DIM * MAX_DIM;
  localparam int ST_AW       = $clog2(ST_DEPTH);
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int IN_TDATA_W  = ((ELEM_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 2 * DIM_W + ACC_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INNER = CFG_IDX_W'(2);

  typedef struct packed {
    logic                     is_left;
    logic signed [ELEM_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [DIMV_W-1:0] m;
    logic [DIMV_W-1:0] n;
    logic [DIMV_W-1:0] k;
  } dims_t;

  function automatic logic [DIMV_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIMV_W-1:0] r;
    if (v == '0) begin
      r = DIMV_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIMV_W'(MAX_DIM);
    end else begin
      r = DIMV_W'(v);
    end
    return r;
  endfunction

endpackage

[rtl/core/mmrs_front.sv]
// Input side: accepts transactions, tags their kind and buffers them in a two-entry queue.
`timescale 1ns / 1ps

module mmrs_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mmrs_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                            in_tuser,
  output logic                            q_valid,
  output mmrs_pkg::item_t                 q_item,
  input  logic                            q_pop
);

  mmrs_pkg::item_t slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  logic       pop;
  mmrs_pkg::item_t new_item;

  assign in_tready = (count_r != 2'd2);
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    new_item.is_left = in_tuser;
    new_item.value   = $signed(in_tdata[mmrs_pkg::ELEM_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

[rtl/core/mmrs_back.sv]
// Execution side: right-matrix store, shared multiply-accumulate, accumulators and result register.
`timescale 1ns / 1ps

module mmrs_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mmrs_pkg::dims_t                  dims,
  input  logic                             q_valid,
  input  mmrs_pkg::item_t                  q_item,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mmrs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast
);

  localparam int OUT_TDATA_W = mmrs_pkg::OUT_TDATA_W;
  localparam int DIM_W       = mmrs_pkg::DIM_W;
  localparam int DIMV_W      = mmrs_pkg::DIMV_W;
  localparam int ELEM_W      = mmrs_pkg::ELEM_W;
  localparam int ACC_W       = mmrs_pkg::ACC_W;
  localparam int ST_AW       = mmrs_pkg::ST_AW;
  localparam int PROD_W      = mmrs_pkg::PROD_W;
  localparam int ADDR_SUM_W  = DIM_W + DIMV_W + 1;
  localparam int TOTAL_W     = 2 * DIMV_W;

  typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_DRAIN, ST_EMIT} state_t;

  state_t state_r;

  logic [ELEM_W-1:0]        b_store [mmrs_pkg::ST_DEPTH];
  logic [ST_AW-1:0]         load_ptr_r;
  logic [DIM_W-1:0]         inner_pos_r;
  logic [DIM_W-1:0]         row_r;
  logic [DIM_W-1:0]         col_r;
  logic signed [ELEM_W-1:0] a_r;

  logic                     p1_vld_r;
  logic [DIM_W-1:0]         p1_col_r;
  logic signed [ELEM_W-1:0] rd_data_r;
  logic                     p2_vld_r;
  logic [DIM_W-1:0]         p2_col_r;
  logic signed [PROD_W-1:0] prod_r;

  logic [ACC_W-1:0]         acc_r     [mmrs_pkg::MAX_DIM];
  logic [mmrs_pkg::MAX_DIM-1:0] acc_vld_r;

  logic                     out_tvalid_r;
  logic [OUT_TDATA_W-1:0]   out_tdata_r;
  logic                     out_tlast_r;

  logic                     pop;
  logic                     do_load;
  logic                     do_issue;
  logic                     last_col;
  logic                     emit_fire;
  logic                     out_free;
  logic [ADDR_SUM_W-1:0]    rd_addr_full;
  logic [ST_AW-1:0]         rd_addr;
  logic [TOTAL_W-1:0]       total;
  logic [TOTAL_W-1:0]       ptr_inc;
  logic [DIM_W-1:0]         acc_idx;
  logic [ACC_W-1:0]         acc_cur;
  logic [ACC_W-1:0]         prod_ext;

  assign pop      = (state_r == ST_IDLE) && q_valid;
  assign q_pop    = pop;
  assign do_load  = pop && !q_item.is_left;
  assign do_issue = (state_r == ST_MAC);
  assign last_col = ((DIMV_W'(col_r) + DIMV_W'(1)) >= dims.n);
  assign out_free = !out_tvalid_r || out_tready;
  assign emit_fire = (state_r == ST_EMIT) && out_free;

  // Store address is l*n + j, folded to the store depth.
  assign rd_addr_full = ADDR_SUM_W'(inner_pos_r) * ADDR_SUM_W'(dims.n) + ADDR_SUM_W'(col_r);
  assign rd_addr      = rd_addr_full[ST_AW-1:0];

  assign total   = TOTAL_W'(dims.k) * TOTAL_W'(dims.n);
  assign ptr_inc = TOTAL_W'(load_ptr_r) + TOTAL_W'(1);

  // One accumulator port: the pipeline tail uses it while multiplying, the
  // result register while a row is emitted; the two never overlap.
  assign acc_idx  = (state_r == ST_EMIT) ? col_r : p2_col_r;
  assign acc_cur  = acc_vld_r[acc_idx] ? acc_r[acc_idx] : '0;
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // Right-matrix store and the multiply pipeline.
  always_ff @(posedge clk) begin
    if (do_load) begin
      b_store[load_ptr_r] <= q_item.value;
    end
    rd_data_r <= $signed(b_store[rd_addr]);
    p1_col_r  <= col_r;
    prod_r    <= a_r * rd_data_r;
    p2_col_r  <= p1_col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= do_issue;
      p2_vld_r <= p1_vld_r;
    end
  end

  // Accumulators; an entry without its valid bit reads as zero.
  always_ff @(posedge clk) begin
    if (p2_vld_r) begin
      acc_r[p2_col_r] <= acc_cur + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= '0;
    end else if (emit_fire && last_col) begin
      acc_vld_r <= '0;
    end else if (p2_vld_r) begin
      acc_vld_r[p2_col_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      load_ptr_r   <= '0;
      inner_pos_r  <= '0;
      row_r        <= '0;
      col_r        <= '0;
      a_r          <= '0;
      out_tvalid_r <= 1'b0;
      out_tdata_r  <= '0;
      out_tlast_r  <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            if (q_item.is_left) begin
              a_r     <= q_item.value;
              col_r   <= '0;
              state_r <= ST_MAC;
            end else if (ptr_inc >= total) begin
              load_ptr_r <= '0;
            end else begin
              load_ptr_r <= ptr_inc[ST_AW-1:0];
            end
          end
        end
        ST_MAC: begin
          if (last_col) begin
            state_r <= ST_DRAIN;
          end else begin
            col_r <= col_r + DIM_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!p1_vld_r && !p2_vld_r) begin
            col_r <= '0;
            if ((DIMV_W'(inner_pos_r) + DIMV_W'(1)) >= dims.k) begin
              inner_pos_r <= '0;
              state_r     <= ST_EMIT;
            end else begin
              inner_pos_r <= inner_pos_r + DIM_W'(1);
              state_r     <= ST_IDLE;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= OUT_TDATA_W'({acc_cur, col_r, row_r});
            out_tlast_r  <= last_col;
            if (last_col) begin
              col_r   <= '0;
              state_r <= ST_IDLE;
              if ((DIMV_W'(row_r) + DIMV_W'(1)) >= dims.m) begin
                row_r <= '0;
              end else begin
                row_r <= row_r + DIM_W'(1);
              end
            end else begin
              col_r <= col_r + DIM_W'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/matrix_multiply_row_stream.sv]
// Top level of the streaming matrix multiplier: configuration registers, front and back halves.
//
//  channel  direction  handshake                       payload
//  in_      slave      in_tvalid / in_tready           tdata = element, tuser = kind
//  out_     master     out_tvalid / out_tready         tdata = row, column, sum; tlast
//  cfg_     slave      cfg_valid / cfg_ready           cfg_index, cfg_data
//
// A right-matrix load is written to the store as it leaves the queue. A left-matrix element
// is worked off by the single multiply-accumulate walking the n columns of one store row,
// and no new element is taken until it is done; the element that closes a row then emits it.
// Reset is synchronous and active low; the store needs no clearing pass.
// The two-entry input queue keeps accepting, until it is full, while the back half works or the
// result register waits on out_tready.
`timescale 1ns / 1ps

module matrix_multiply_row_stream (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [mmrs_pkg::IN_TDATA_W-1:0]          in_tdata,   // [15:0] value
  input  logic                                     in_tuser,   // [0] op
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [mmrs_pkg::OUT_TDATA_W-1:0]         out_tdata,  // [3:0] row, [7:4] column,
                                                               // [43:8] sum, rest zero
  output logic                                     out_tlast,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [mmrs_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [mmrs_pkg::CFG_W-1:0]               cfg_data
);

  localparam int CFG_W = mmrs_pkg::CFG_W;

  logic [CFG_W-1:0] rows_r;
  logic [CFG_W-1:0] cols_r;
  logic [CFG_W-1:0] inner_r;
  mmrs_pkg::dims_t  dims;
  logic             q_valid;
  logic             q_pop;
  mmrs_pkg::item_t  q_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    dims.m = mmrs_pkg::clamp_dim(rows_r);
    dims.n = mmrs_pkg::clamp_dim(cols_r);
    dims.k = mmrs_pkg::clamp_dim(inner_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= CFG_W'(mmrs_pkg::MAX_DIM);
      cols_r  <= CFG_W'(mmrs_pkg::MAX_DIM);
      inner_r <= CFG_W'(mmrs_pkg::MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mmrs_pkg::REG_ROWS:  rows_r  <= cfg_data;
        mmrs_pkg::REG_COLS:  cols_r  <= cfg_data;
        mmrs_pkg::REG_INNER: inner_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mmrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  mmrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dims       (dims),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the streaming matrix multiplier, with its own predictor of C = A x B.
`timescale 1ns / 1ps

module testbench;
  import mmrs_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 400;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(3);
  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W - 1){1'b0}}};
  localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W - 1){1'b1}}};

  typedef enum logic {LOAD_RIGHT = 1'b0, STREAM_LEFT = 1'b1} elem_kind_e;

  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] column;
    logic [ACC_W-1:0] sum;
    logic             last;
  } row_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  // Predictor state: register values as written, the right-matrix store and the row sums.
  logic [CFG_W-1:0]         rows_reg = CFG_W'(MAX_DIM);
  logic [CFG_W-1:0]         cols_reg = CFG_W'(MAX_DIM);
  logic [CFG_W-1:0]         inner_reg = CFG_W'(MAX_DIM);
  logic signed [ELEM_W-1:0] right_store [ST_DEPTH];
  bit                       right_loaded [ST_DEPTH];
  logic signed [ACC_W-1:0]  row_sums [MAX_DIM];
  int                       load_ptr;
  int                       inner_pos;
  int                       row_idx;
  row_result_t              pending_products [$];

  bit steady;
  int errors;
  int items_accepted;
  int left_items;
  int results_checked;
  int cfg_writes;
  int stall_cycles;

  matrix_multiply_row_stream dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int dim_of(input logic [CFG_W-1:0] code);
    if (code == '0) return 1;
    if (code > MAX_DIM) return MAX_DIM;
    return int'(code);
  endfunction

  // True when the next left element only touches store entries that were loaded.
  function automatic bit left_reads_loaded();
    int n;
    bit ok;
    n = dim_of(cols_reg);
    ok = 1'b1;
    for (int j = 0; j < n; j++) begin
      if (!right_loaded[(inner_pos * n + j) % ST_DEPTH]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void accumulate_element(input elem_kind_e kind,
                                             input logic signed [ELEM_W-1:0] value);
    int m;
    int n;
    int k;
    int addr;
    row_result_t r;
    m = dim_of(rows_reg);
    n = dim_of(cols_reg);
    k = dim_of(inner_reg);
    if (kind == LOAD_RIGHT) begin
      right_store[load_ptr % ST_DEPTH] = value;
      right_loaded[load_ptr % ST_DEPTH] = 1'b1;
      load_ptr = (load_ptr + 1 >= k * n) ? 0 : load_ptr + 1;
      return;
    end
    for (int j = 0; j < n; j++) begin
      addr = (inner_pos * n + j) % ST_DEPTH;
      row_sums[j] = row_sums[j] + ACC_W'(longint'(value) * longint'(right_store[addr]));
    end
    if (inner_pos + 1 < k) begin
      inner_pos++;
      return;
    end
    for (int j = 0; j < n; j++) begin
      r.row = DIM_W'(row_idx);
      r.column = DIM_W'(j);
      r.sum = row_sums[j];
      r.last = (j == n - 1);
      pending_products.push_back(r);
    end
    foreach (row_sums[j]) row_sums[j] = '0;
    inner_pos = 0;
    row_idx = (row_idx + 1 >= m) ? 0 : row_idx + 1;
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return ELEM_MIN;
      1: return ELEM_MAX;
      2: return '0;
      3: return '1;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim_code();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return CFG_W'(MAX_DIM);
      3: return CFG_W'(1);
      4: return CFG_W'($urandom_range(MAX_DIM + 1, 30));
      default: return CFG_W'($urandom_range(2, 5));
    endcase
  endfunction

  task automatic send_item(input elem_kind_e kind, input logic [ELEM_W-1:0] value);
    // A left element that would read an unloaded store entry is sent as a load instead.
    if (kind == STREAM_LEFT && !left_reads_loaded()) kind = LOAD_RIGHT;
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(0, 99) < 16) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = value;
    do @(posedge clk); while (!in_tready);
    accumulate_element(kind, value);
    items_accepted++;
    if (kind == STREAM_LEFT) left_items++;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] code);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = code;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ROWS:  rows_reg = code;
      REG_COLS:  cols_reg = code;
      REG_INNER: inner_reg = code;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stops the sender and waits until every expected result is out and the block is quiet.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_small_product();
    logic [ELEM_W-1:0] left_vals [6];
    left_vals = '{ELEM_MIN, ELEM_MAX, '0, '1, ELEM_W'(1), ELEM_MIN};
    write_register(REG_ROWS, CFG_W'(2));
    write_register(REG_COLS, CFG_W'(2));
    write_register(REG_INNER, CFG_W'(2));
    send_item(LOAD_RIGHT, ELEM_MAX);
    send_item(LOAD_RIGHT, ELEM_MIN);
    send_item(LOAD_RIGHT, '1);
    send_item(LOAD_RIGHT, ELEM_W'(1));
    // Three rows, so the row index wraps back to zero on the last one.
    foreach (left_vals[i]) send_item(STREAM_LEFT, left_vals[i]);
    drain_results();
  endtask

  task automatic test_clamped_dims();
    // Zero acts as one, anything above the maximum acts as the maximum.
    write_register(REG_ROWS, '0);
    write_register(REG_COLS, '1);
    write_register(REG_INNER, '0);
    write_register(REG_NONE, '1);
    repeat (MAX_DIM) send_item(LOAD_RIGHT, rand_elem());
    repeat (2) send_item(STREAM_LEFT, rand_elem());
    drain_results();
  endtask

  task automatic test_extreme_sum();
    write_register(REG_COLS, '0);
    write_register(REG_INNER, CFG_W'(MAX_DIM));
    repeat (MAX_DIM) send_item(LOAD_RIGHT, ELEM_MIN);
    repeat (MAX_DIM) send_item(STREAM_LEFT, ELEM_MIN);
    drain_results();
  endtask

  task automatic test_dims_changed_midway();
    write_register(REG_ROWS, CFG_W'(4));
    write_register(REG_COLS, CFG_W'(3));
    write_register(REG_INNER, CFG_W'(3));
    repeat (9) send_item(LOAD_RIGHT, rand_elem());
    repeat (4) send_item(STREAM_LEFT, rand_elem());
    repeat (4) send_item(LOAD_RIGHT, rand_elem());
    drain_results();
    // Load pointer and inner position now lie past the shorter inner length.
    write_register(REG_INNER, CFG_W'(1));
    send_item(LOAD_RIGHT, rand_elem());
    send_item(STREAM_LEFT, rand_elem());
    drain_results();
    // Row index now lies past the row count and has to wrap on the next row.
    write_register(REG_ROWS, CFG_W'(1));
    repeat (2) send_item(STREAM_LEFT, rand_elem());
    drain_results();
  endtask

  task automatic test_random_phases();
    int start;
    int n;
    int k;
    logic [CFG_W-1:0] inner_code;
    start = items_accepted;
    while (items_accepted - start < RANDOM_ITEMS) begin
      steady = (items_accepted - start >= 180) && (items_accepted - start < 300);
      if ($urandom_range(0, 4) != 0) write_register(REG_ROWS, rand_dim_code());
      if ($urandom_range(0, 4) != 0) write_register(REG_COLS, rand_dim_code());
      if ($urandom_range(0, 9) == 0) write_register(REG_NONE, CFG_W'($urandom));
      // Keep the right matrix small so that most phases stay short.
      inner_code = rand_dim_code();
      if (dim_of(inner_code) * dim_of(cols_reg) > 32) begin
        inner_code = CFG_W'($urandom_range(0, 32 / dim_of(cols_reg)));
      end
      write_register(REG_INNER, inner_code);
      n = dim_of(cols_reg);
      k = dim_of(inner_reg);
      if ($urandom_range(0, 3) != 0) begin
        repeat (n * k) send_item(LOAD_RIGHT, rand_elem());
        repeat ($urandom_range(1, 3) * k) send_item(STREAM_LEFT, rand_elem());
      end else begin
        repeat ($urandom_range(4, 16)) send_item(elem_kind_e'($urandom_range(0, 1)), rand_elem());
      end
      drain_results();
    end
    steady = 1'b0;
  endtask

  initial begin
    foreach (row_sums[j]) row_sums[j] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_small_product();
    test_clamped_dims();
    test_extreme_sum();
    test_dims_changed_midway();
    test_random_phases();
    drain_results();
    $display("Covered %0d items (%0d left elements), %0d checked results, %0d register writes,",
             items_accepted, left_items, results_checked, cfg_writes);
    $display("including clamped sizes, extreme sums and sizes changed in the middle of a row.");
    if (errors == 0) begin
      $display("matrix_multiply_row_stream verification clean");
    end else begin
      $display("matrix_multiply_row_stream verification failed");
    end
    $finish;
  end

  always @(negedge clk) begin
    out_tready = steady || ($urandom_range(0, 99) >= 16);
  end

  task automatic check_field(input string name, input logic [ACC_W-1:0] want,
                             input logic [ACC_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Each result transaction is compared with the oldest expected result.
  always @(posedge clk) begin
    row_result_t want;
    if (out_tvalid && out_tready) begin
      if (pending_products.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h last %b",
                 $time, out_tdata, out_tlast);
      end else begin
        want = pending_products.pop_front();
        results_checked++;
        check_field("row", ACC_W'(want.row), ACC_W'(out_tdata[DIM_W-1:0]));
        check_field("column", ACC_W'(want.column), ACC_W'(out_tdata[2*DIM_W-1:DIM_W]));
        check_field("product", want.sum, out_tdata[2*DIM_W+ACC_W-1:2*DIM_W]);
        check_field("last", ACC_W'(want.last), ACC_W'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, stall_cycles, pending_products.size());
      $display("matrix_multiply_row_stream verification failed");
      $finish;
    end
  end

endmodule
